@@ hdl/pnsm_pkg.sv @@
// ----------------------------------------------------------------------------
// pnsm_pkg
// Shared types and constants for the peak-normalized step magnitude block.
// ----------------------------------------------------------------------------
package pnsm_pkg;

  localparam int INTERVAL_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CEILING_RESET_WIDTH = 17;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CEILING  = 2'd1;

  localparam logic [INTERVAL_WIDTH-1:0]      INTERVAL_RESET = 16'd1;
  localparam logic [CEILING_RESET_WIDTH-1:0] CEILING_RESET  = 17'd65470;

  // series phase codes
  localparam logic [1:0] PHASE_EMPTY = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_RUN   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture the accepted sample
    logic restart;    // first sample: keep it, clear the peak
    logic calc_step;  // register the absolute step, keep the sample
    logic upd_peak;   // raise the peak, seed the divider
    logic div_step;   // one restoring division iteration
    logic div_first;  // integer bit: compare without shifting
    logic out_load;   // load the result register
    logic out_last;   // last result of this item
  } pnsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_start;   // held series_start flag
    logic out_free;   // result register can take a new result
  } pnsm_status_t;

endpackage

@@ hdl/pnsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnsm_ctrl
// Sequencer: accepts a sample and, unless it is a series' first sample (which
// only restarts the history), steps the datapath through step, peak and
// division, then hands one or two results to the output register.
module pnsm_ctrl
  import pnsm_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  pnsm_status_t status,
  output pnsm_cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_PEAK  = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_EMIT2 = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [1:0]       phase, phase_next;
  logic             two, two_next;
  logic [CNT_W-1:0] count, count_next;
  logic             first_sample;

  assign in_stall = (state != S_IDLE);
  assign first_sample = status.in_start || (phase == PHASE_EMPTY);

  always_comb begin
    state_next = state;
    phase_next = phase;
    two_next   = two;
    count_next = count;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        if (first_sample) begin
          cmd.restart = 1'b1;
          phase_next  = PHASE_ONE;
          state_next  = S_IDLE;
        end else begin
          cmd.calc_step = 1'b1;
          two_next      = (phase == PHASE_ONE);
          phase_next    = PHASE_RUN;
          state_next    = S_PEAK;
        end
      end
      S_PEAK: begin
        cmd.upd_peak = 1'b1;
        count_next   = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (count == '0);
        count_next    = count + 1'b1;
        if (count == CNT_W'(FRACTION_BITS)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !two;
          state_next   = two ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PHASE_EMPTY;
      two   <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      two   <= two_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/pnsm_dp.sv @@
// ----------------------------------------------------------------------------
// pnsm_dp
// Datapath: sample history, absolute step, running peak, bit-serial
// restoring divider, ceiling clamp, configuration and result registers.
// ----------------------------------------------------------------------------
module pnsm_dp
  import pnsm_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pnsm_cmd_t                           cmd,
  output pnsm_status_t                        status,
  input  logic                                cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]          cfg_index,
  input  logic [((FRACTION_BITS + 1 > INTERVAL_WIDTH) ?
                 FRACTION_BITS + 1 : INTERVAL_WIDTH)-1:0] cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]      price,
  input  logic                                series_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [FRACTION_BITS-1:0]            beta,
  output logic                                interval_error,
  output logic                                last_of_run
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int CEIL_W = FRACTION_BITS + 1;
  localparam logic [CEIL_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [CEIL_W-1:0] CEIL_RST =
    (CEIL_W >= CEILING_RESET_WIDTH) ? CEIL_W'(CEILING_RESET) : {CEIL_W{1'b1}};

  logic [INTERVAL_WIDTH-1:0] sample_interval;
  logic [CEIL_W-1:0]         beta_ceiling;
  logic [W-1:0]              sample;
  logic                      start;
  logic [W-1:0]              previous_sample;
  logic [W-1:0]              step;
  logic [W-1:0]              peak_step;
  logic [W:0]                rem;
  logic [CEIL_W-1:0]         quot;

  logic [W-1:0]      ua, ub;
  logic [W:0]        diff_ab;
  logic [W-1:0]      diff_ba;
  logic [W-1:0]      abs_step;
  logic [W:0]        trial;
  logic              fits;
  logic [CEIL_W-1:0] limit;
  logic [CEIL_W-1:0] clamped;
  logic              err;
  logic              out_free;

  assign status.in_start = start;
  assign status.out_free = out_free;

  // offset binary makes the signed compare an unsigned one
  assign ua       = sample ^ {1'b1, {(W-1){1'b0}}};
  assign ub       = previous_sample ^ {1'b1, {(W-1){1'b0}}};
  assign diff_ab  = {1'b0, ua} - {1'b0, ub};
  assign diff_ba  = ub - ua;
  assign abs_step = diff_ab[W] ? diff_ba : diff_ab[W-1:0];

  assign trial = cmd.div_first ? rem : {rem[W-1:0], 1'b0};
  assign fits  = (trial >= {1'b0, peak_step});

  assign limit = (beta_ceiling >= FRAC_ONE) ? FRAC_ONE : beta_ceiling;
  assign err   = (sample_interval == '0);

  always_comb begin
    if (err || peak_step == '0 || limit == '0) begin
      clamped = '0;
    end else if (quot >= limit) begin
      clamped = limit - 1'b1;
    end else begin
      clamped = quot;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= INTERVAL_RESET;
      beta_ceiling    <= CEIL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTERVAL: sample_interval <= cfg_data[INTERVAL_WIDTH-1:0];
        REG_CEILING:  beta_ceiling    <= cfg_data[CEIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      peak_step       <= '0;
    end else if (cmd.restart) begin
      previous_sample <= sample;
      peak_step       <= '0;
    end else if (cmd.calc_step) begin
      previous_sample <= sample;
    end else if (cmd.upd_peak && step > peak_step) begin
      peak_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample <= price;
      start  <= series_start;
    end
    if (cmd.calc_step) begin
      step <= abs_step;
    end
    // seed with the step; the new peak lands in the same edge
    if (cmd.upd_peak) begin
      rem  <= {1'b0, step};
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= fits ? trial - {1'b0, peak_step} : trial;
      quot <= {quot[CEIL_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      beta           <= clamped[FRACTION_BITS-1:0];
      interval_error <= err;
      last_of_run    <= cmd.out_last;
    end
  end

endmodule

@@ hdl/peak_normalized_step_magnitude.sv @@
// Each accepted sample passes through step, peak, FRACTION_BITS+1 divider
// iterations and result load before a first result is valid; a second result
// follows once the first is taken. A series' first sample gives no result and
// only restarts the history. The input stays stalled until a sample's results
// are loaded, so only one sample is in flight. Synchronous active-high reset
// clears series state, configuration and the output valid flag.
// ----------------------------------------------------------------------------
// peak_normalized_step_magnitude
// Ratio of each absolute price step to the running peak step of the series,
// as an unsigned fraction held below a programmable ceiling.
// ----------------------------------------------------------------------------
module peak_normalized_step_magnitude
  import pnsm_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [((FRACTION_BITS + 1 > INTERVAL_WIDTH) ?
                 FRACTION_BITS + 1 : INTERVAL_WIDTH)-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] price,
  input  logic                           series_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [FRACTION_BITS-1:0]       beta,
  output logic                           interval_error,
  output logic                           last_of_run
);

  pnsm_cmd_t    cmd;
  pnsm_status_t status;

  pnsm_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  pnsm_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .price         (price),
    .series_start  (series_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .beta          (beta),
    .interval_error(interval_error),
    .last_of_run   (last_of_run)
  );

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && out_valid |-> !out_stall)
    else $error("result register overwritten while stalled");

  // one sample at a time: the transfer closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the sample was processed");

  // a flagged interval always carries a zero ratio
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && interval_error |-> beta == '0)
    else $error("nonzero beta with interval error");

endmodule
